FILE: rtl/core/sfir_pkg.sv
// ----------------------------------------------------------------------------
// sfir_pkg: shared constants and types for the symmetric FIR filter
// Filter order, ring and half-table sizes, datapath widths, item kind codes,
// and the command and status words between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sfir_pkg;

    // Filter geometry
    localparam int ORDER      = 63;
    localparam int RING_LEN   = ORDER + 1;
    localparam int HALF_LEN   = ORDER / 2 + 1;
    localparam int PAIR_COUNT = (ORDER + 1) / 2;
    localparam bit HAS_MIDDLE = (ORDER % 2) == 0;

    // Address and counter widths
    localparam int RA_W  = $clog2(RING_LEN);
    localparam int HA_W  = (HALF_LEN > 1) ? $clog2(HALF_LEN) : 1;
    localparam int CNT_W = $clog2(HALF_LEN + 1);

    // Datapath widths
    localparam int SMP_W  = 16;
    localparam int COEF_W = 16;
    localparam int IDX_W  = 5;
    localparam int PAIR_W = SMP_W + 1;
    localparam int PROD_W = PAIR_W + COEF_W;
    localparam int ACC_W  = PROD_W + 1 + HA_W;
    localparam int FRAC_W = 15;
    localparam int Q_W    = ACC_W - FRAC_W;

    // Item kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic            wr_sample;
        logic            wr_coef;
        logic            issue;
        logic            mid;
        logic [HA_W-1:0] step;
        logic            bias;
        logic            load_out;
    } sfir_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pipe_idle;
    } sfir_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfir_ram.sv
// ----------------------------------------------------------------------------
// sfir_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sfir_dp.sv
// ----------------------------------------------------------------------------
// sfir_dp: symmetric FIR datapath
// Sample ring (two RAM copies for the mirrored reads), coefficient half
// table, pre-add / multiply / accumulate pipeline, Q15 scaling and output
// saturation. Driven entirely by the controller's command word.
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_dp
    import sfir_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire sfir_cmd_t                cmd,
    input  wire logic signed [SMP_W-1:0]  sample,
    input  wire logic        [IDX_W-1:0]  coef_index,
    input  wire logic signed [COEF_W-1:0] coef_value,
    output sfir_stat_t                    stat,
    output logic signed      [SMP_W-1:0]  filtered
);

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'((1 << FRAC_W) - 1);
    localparam logic signed [Q_W-1:0]   Q_MAX      = Q_W'((1 << (SMP_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]   Q_MIN      = Q_W'(-(1 << (SMP_W - 1)));

    // Ring pointers and entry valid bits
    logic [RA_W-1:0]     wp_reg;
    logic [RA_W-1:0]     newer_reg;
    logic [RA_W-1:0]     older_reg;
    logic [RING_LEN-1:0] ring_vld_reg;
    logic [HALF_LEN-1:0] coef_vld_reg;

    // Pipeline stages
    logic                      s1_vld_reg;
    logic                      s1_a_vld_reg;
    logic                      s1_b_vld_reg;
    logic                      s1_c_vld_reg;
    logic                      s1_mid_reg;
    logic                      s2_vld_reg;
    logic                      s3_vld_reg;
    logic signed [PAIR_W-1:0]  pair_reg;
    logic signed [PAIR_W-1:0]  pair_next;
    logic signed [COEF_W-1:0]  coef2_reg;
    logic signed [COEF_W-1:0]  coef2_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   biased_reg;
    logic signed [SMP_W-1:0]   filtered_reg;
    logic signed [SMP_W-1:0]   filtered_next;

    // RAM data
    logic [SMP_W-1:0]  ring_a_q;
    logic [SMP_W-1:0]  ring_b_q;
    logic [COEF_W-1:0] coef_q;

    logic                    coef_hit;
    logic                    coef_we;
    logic [HA_W-1:0]         coef_waddr;
    logic signed [SMP_W-1:0] a_val;
    logic signed [SMP_W-1:0] b_val;
    logic signed [Q_W-1:0]   q_val;

    function automatic logic [RA_W-1:0] ring_next(input logic [RA_W-1:0] p);
        logic [RA_W-1:0] r;
        if (p == RA_W'(RING_LEN - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [RA_W-1:0] ring_prev(input logic [RA_W-1:0] p);
        logic [RA_W-1:0] r;
        if (p == '0)
        begin
            r = RA_W'(RING_LEN - 1);
        end
        else
        begin
            r = p - 1'b1;
        end
        return r;
    endfunction

    // Ignore loads beyond the half table
    assign coef_hit   = {{(32 - IDX_W){1'b0}}, coef_index} < 32'(HALF_LEN);
    assign coef_we    = cmd.wr_coef && coef_hit;
    assign coef_waddr = HA_W'(coef_index);

    // Sample ring, newer-side copy
    sfir_ram #(
        .WIDTH (SMP_W),
        .DEPTH (RING_LEN)
    ) u_ring_a (
        .clk   (clk),
        .we    (cmd.wr_sample),
        .waddr (wp_reg),
        .wdata (sample),
        .raddr (newer_reg),
        .rdata (ring_a_q)
    );

    // Sample ring, older-side copy
    sfir_ram #(
        .WIDTH (SMP_W),
        .DEPTH (RING_LEN)
    ) u_ring_b (
        .clk   (clk),
        .we    (cmd.wr_sample),
        .waddr (wp_reg),
        .wdata (sample),
        .raddr (older_reg),
        .rdata (ring_b_q)
    );

    // Coefficient half table
    sfir_ram #(
        .WIDTH (COEF_W),
        .DEPTH (HALF_LEN)
    ) u_coef (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_value),
        .raddr (cmd.step),
        .rdata (coef_q)
    );

    // Advance ring pointers, track written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            newer_reg    <= '0;
            older_reg    <= '0;
            ring_vld_reg <= '0;
            coef_vld_reg <= '0;
        end
        else
        begin
            if (cmd.wr_sample)
            begin
                ring_vld_reg[wp_reg] <= 1'b1;
                newer_reg            <= wp_reg;
                older_reg            <= ring_next(wp_reg);
                wp_reg               <= ring_next(wp_reg);
            end
            else if (cmd.issue)
            begin
                newer_reg <= ring_prev(newer_reg);
                older_reg <= ring_next(older_reg);
            end
            if (coef_we)
            begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // Carry entry valid bits alongside the registered read data
    always_ff @(posedge clk)
    begin
        s1_a_vld_reg <= ring_vld_reg[newer_reg];
        s1_b_vld_reg <= ring_vld_reg[older_reg];
        s1_c_vld_reg <= coef_vld_reg[cmd.step];
        s1_mid_reg   <= cmd.mid;
    end

    // Pre-add mirrored pair; unwritten entries read as zero
    always_comb
    begin
        a_val      = s1_a_vld_reg ? $signed(ring_a_q) : '0;
        b_val      = (s1_b_vld_reg && !s1_mid_reg) ? $signed(ring_b_q) : '0;
        coef2_next = s1_c_vld_reg ? $signed(coef_q) : '0;
        pair_next  = PAIR_W'(a_val) + PAIR_W'(b_val);
        prod_next  = PROD_W'(pair_reg) * PROD_W'(coef2_reg);
    end

    // Pre-add and multiply stages
    always_ff @(posedge clk)
    begin
        pair_reg  <= pair_next;
        coef2_reg <= coef2_next;
        prod_reg  <= prod_next;
    end

    // Accumulate, then bias negative sums for truncation toward zero
    always_ff @(posedge clk)
    begin
        if (cmd.wr_sample)
        begin
            acc_reg <= '0;
        end
        else if (s3_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.bias)
        begin
            biased_reg <= acc_reg[ACC_W-1] ? acc_reg + ROUND_BIAS : acc_reg;
        end
    end

    // Drop the Q15 fraction and saturate
    always_comb
    begin
        q_val = biased_reg[ACC_W-1:FRAC_W];
        priority if (q_val > Q_MAX)
        begin
            filtered_next = Q_MAX[SMP_W-1:0];
        end
        else if (q_val < Q_MIN)
        begin
            filtered_next = Q_MIN[SMP_W-1:0];
        end
        else
        begin
            filtered_next = q_val[SMP_W-1:0];
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            filtered_reg <= filtered_next;
        end
    end

    assign filtered       = filtered_reg;
    assign stat.pipe_idle = !s1_vld_reg && !s2_vld_reg && !s3_vld_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sfir_ctrl.sv
// ----------------------------------------------------------------------------
// sfir_ctrl: symmetric FIR controller
// Accepts input words, steps the datapath through one pair per cycle,
// waits for the pipeline to drain, scales and hands over the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module sfir_ctrl
    import sfir_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       func,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire sfir_stat_t stat,
    output sfir_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             in_take;

    assign in_stall = state_reg != ST_IDLE;
    assign in_take  = in_valid && !in_stall;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.step       = cnt_reg[HA_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (func == FUNC_LOAD)
                    begin
                        cmd.wr_coef = 1'b1;
                    end
                    else
                    begin
                        cmd.wr_sample = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                cmd.mid   = HAS_MIDDLE && (cnt_reg == CNT_W'(PAIR_COUNT));
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HALF_LEN - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_idle)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.bias   = 1'b1;
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Step index never runs past the half table
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (cnt_reg < CNT_W'(HALF_LEN)))
        else $error("pair step issued beyond half table");

    // A new word never overwrites one still waiting at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid_reg && out_stall))
        else $error("output word overwritten while stalled");

    // Scaling starts only after the last product has been accumulated
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> stat.pipe_idle)
        else $error("scaling started with pipeline busy");

    // An accepted sample starts the pair sweep at step zero
    a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && func == FUNC_SAMPLE)
        |=> (state_reg == ST_RUN && cnt_reg == '0))
        else $error("sample accepted without starting the sweep");

endmodule

`default_nettype wire

FILE: rtl/core/symmetric_fir_filter.sv
// ----------------------------------------------------------------------------
// symmetric_fir_filter: mono linear-phase FIR filter, symmetric Q15 taps
// Input channel: in_valid / in_stall with func, sample, coef_index and
// coef_value. A word with func = 1 loads one half-table coefficient
// (positions beyond the half table are ignored) and produces no output.
// A word with func = 0 is an audio sample: it enters the sample ring and
// produces one filtered word.
// Output channel: out_valid / out_stall with filtered. The word is held in
// an output register, so the next input word is taken while a result
// still waits.
// Timing: the sweep issues one mirrored pair per cycle from the two ring
// copies and the coefficient RAM, HALF_LEN steps (32 at ORDER = 63). After
// the sweep the controller waits for the pipeline to drain, biases the
// sum and loads the saturated result; then the next word is taken.
// Stall: a stalled output holds filtered unchanged; if a second result is
// ready before the first is taken, the controller waits and in_stall stays
// high.
// Reset: ring, write pointer and coefficients read as zero; no word is
// pending on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetric_fir_filter
    import sfir_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     func,
    input  wire logic signed [SMP_W-1:0]  sample,
    input  wire logic        [IDX_W-1:0]  coef_index,
    input  wire logic signed [COEF_W-1:0] coef_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed      [SMP_W-1:0]  filtered
);

    sfir_cmd_t  cmd;
    sfir_stat_t stat;

    // Sequencing
    sfir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage and arithmetic
    sfir_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample     (sample),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .stat       (stat),
        .filtered   (filtered)
    );

endmodule

`default_nettype wire
